FILE: design/mstb_pkg.sv
// Shared constants and types for the media sample table builder.
package mstb_pkg;

  // Default number of track slots
  localparam int MAX_TRACKS_DEF = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_TRACK_COUNT = 3'd0;
  localparam logic [2:0] REG_VIDEO_MASK  = 3'd1;
  localparam logic [2:0] REG_DATA_START  = 3'd2;
  localparam logic [2:0] REG_IDS_0_1     = 3'd3;
  localparam logic [2:0] REG_IDS_2_3     = 3'd4;
  localparam logic [2:0] REG_IDS_4_5     = 3'd5;
  localparam logic [2:0] REG_IDS_6_7     = 3'd6;

  // Reset values of the configuration registers
  localparam logic [3:0]  TRACK_COUNT_RST = 4'd1;
  localparam logic [63:0] DATA_START_RST  = 64'd40;

  // Per-slot bookkeeping record held in the state RAM
  typedef struct packed {
    logic [31:0] samples;
    logic [31:0] runs;
    logic [31:0] run_delta;
    logic [31:0] run_count;
    logic [31:0] keys;
    logic [31:0] max_size;
    logic [63:0] ticks;
  } slot_state_t;

  localparam int SLOT_STATE_W = $bits(slot_state_t);

  // Saturating increment
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Saturating 64-bit add
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? '1 : sum[63:0];
  endfunction

endpackage

FILE: design/mstb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mstb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/media_sample_table_builder.sv
// Media sample table builder: per-track sample, run, key and offset bookkeeping.
//
// Each accepted frame descriptor passes through ST_IDLE and then ST_RMW: the first
// matches the track id against the configured slot ids and reads that slot's record
// from the state RAM, the second updates the record, writes it back and loads the
// result register. The single read-modify-write on the state RAM means a new item
// is taken only after the last is done; a result waiting on out_stall holds off
// the write-back of the next item. Slot records start out as zero through per-slot
// valid bits, so there is no clearing pass after reset. Zero-size frames return
// status 1 with all other fields zero and leave every counter untouched.
module media_sample_table_builder #(
  parameter int MAX_TRACKS = mstb_pkg::MAX_TRACKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // frame descriptor channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_track_ident,
  input  logic [31:0] in_frame_size,
  input  logic [31:0] in_frame_duration,
  input  logic        in_key_flag,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [2:0]  out_track_slot,
  output logic [31:0] out_sample_number,
  output logic [63:0] out_sample_offset,
  output logic [31:0] out_run_index,
  output logic [31:0] out_run_count,
  output logic [31:0] out_run_delta,
  output logic        out_new_run,
  output logic        out_key_recorded,
  output logic [31:0] out_key_entry_count,
  output logic [31:0] out_largest_frame,
  output logic [63:0] out_duration_total,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam logic [3:0] MAX_TRACKS_4 = 4'(MAX_TRACKS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RMW  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [3:0]  track_count_r;
  logic [7:0]  video_mask_r;
  logic [63:0] data_start_r;
  logic [63:0] id_reg_r [4];

  // shared running byte count and per-slot valid bits
  logic [63:0]           payload_bytes_r, payload_bytes_nxt;
  logic [MAX_TRACKS-1:0] slot_valid_r, slot_valid_nxt;

  // latched item
  logic [SLOT_W-1:0] slot_r;
  logic [31:0]       size_r;
  logic [31:0]       dur_r;
  logic              key_r;
  logic              zero_r;

  // output registers
  logic        out_valid_r, out_valid_nxt;
  logic        status_r;
  logic [2:0]  track_slot_r;
  logic [31:0] sample_number_r;
  logic [63:0] sample_offset_r;
  logic [31:0] run_index_r;
  logic [31:0] run_count_r;
  logic [31:0] run_delta_r;
  logic        new_run_r;
  logic        key_recorded_r;
  logic [31:0] key_entry_count_r;
  logic [31:0] largest_frame_r;
  logic [63:0] duration_total_r;

  logic              in_take;
  logic              finish;
  logic [3:0]        n_eff;
  logic [SLOT_W-1:0] match_slot;
  logic              match_found;
  logic [SLOT_W-1:0] ram_raddr;
  logic [mstb_pkg::SLOT_STATE_W-1:0] ram_rdata;
  mstb_pkg::slot_state_t cur, upd;
  logic              ext_run;
  logic              key_rec;
  logic [63:0]       offset;

  // Handshake: one item in flight, result register frees up on take
  assign in_take = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign finish = (state_r == ST_RMW) && (!out_valid_r || !out_stall);

  // Effective slot count: zero acts as one, clamp to MAX_TRACKS
  always_comb begin
    n_eff = track_count_r;
    if (n_eff == 4'd0) begin
      n_eff = 4'd1;
    end else if (n_eff > MAX_TRACKS_4) begin
      n_eff = MAX_TRACKS_4;
    end
  end

  // Lowest matching slot wins, slot 0 on no match
  always_comb begin
    match_slot = '0;
    match_found = 1'b0;
    for (int s = 0; s < MAX_TRACKS; s++) begin
      if (!match_found && (4'(s) < n_eff) &&
          (id_reg_r[2'(s >> 1)][32 * (s & 1) +: 32] == in_track_ident)) begin
        match_slot = SLOT_W'(s);
        match_found = 1'b1;
      end
    end
  end

  assign ram_raddr = (state_r == ST_IDLE) ? match_slot : slot_r;

  mstb_ram #(
    .WIDTH(mstb_pkg::SLOT_STATE_W),
    .DEPTH(MAX_TRACKS)
  ) u_state_ram (
    .clk  (clk),
    .we   (finish && !zero_r),
    .waddr(slot_r),
    .wdata(upd),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Unwritten slots read as zero
  assign cur = slot_valid_r[slot_r] ? mstb_pkg::slot_state_t'(ram_rdata) : '0;

  // Record update
  always_comb begin
    ext_run = (cur.runs != 32'd0) && (cur.run_delta == dur_r);
    key_rec = key_r && video_mask_r[3'(slot_r)];
    offset  = mstb_pkg::sat_add64(data_start_r, payload_bytes_r);
    upd = cur;
    upd.samples  = mstb_pkg::sat_inc32(cur.samples);
    upd.ticks    = mstb_pkg::sat_add64(cur.ticks, {32'd0, dur_r});
    upd.max_size = (cur.max_size < size_r) ? size_r : cur.max_size;
    if (key_rec) begin
      upd.keys = mstb_pkg::sat_inc32(cur.keys);
    end
    if (ext_run) begin
      upd.run_count = mstb_pkg::sat_inc32(cur.run_count);
    end else begin
      upd.runs      = mstb_pkg::sat_inc32(cur.runs);
      upd.run_count = 32'd1;
      upd.run_delta = dur_r;
    end
  end

  // Control next state
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    payload_bytes_nxt = payload_bytes_r;
    slot_valid_nxt = slot_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (finish) begin
          state_nxt = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!zero_r) begin
            payload_bytes_nxt = mstb_pkg::sat_add64(payload_bytes_r, {32'd0, size_r});
            slot_valid_nxt[slot_r] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      payload_bytes_r <= '0;
      slot_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      payload_bytes_r <= payload_bytes_nxt;
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r <= mstb_pkg::TRACK_COUNT_RST;
      video_mask_r <= '0;
      data_start_r <= mstb_pkg::DATA_START_RST;
      for (int i = 0; i < 4; i++) begin
        id_reg_r[i] <= {32'(2 * i + 2), 32'(2 * i + 1)};
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mstb_pkg::REG_TRACK_COUNT: track_count_r <= cfg_data[3:0];
        mstb_pkg::REG_VIDEO_MASK:  video_mask_r <= cfg_data[7:0];
        mstb_pkg::REG_DATA_START:  data_start_r <= cfg_data;
        mstb_pkg::REG_IDS_0_1:     id_reg_r[0] <= cfg_data;
        mstb_pkg::REG_IDS_2_3:     id_reg_r[1] <= cfg_data;
        mstb_pkg::REG_IDS_4_5:     id_reg_r[2] <= cfg_data;
        mstb_pkg::REG_IDS_6_7:     id_reg_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_r <= match_slot;
      size_r <= in_frame_size;
      dur_r  <= in_frame_duration;
      key_r  <= in_key_flag;
      zero_r <= (in_frame_size == 32'd0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (finish) begin
      if (zero_r) begin
        status_r          <= 1'b1;
        track_slot_r      <= '0;
        sample_number_r   <= '0;
        sample_offset_r   <= '0;
        run_index_r       <= '0;
        run_count_r       <= '0;
        run_delta_r       <= '0;
        new_run_r         <= 1'b0;
        key_recorded_r    <= 1'b0;
        key_entry_count_r <= '0;
        largest_frame_r   <= '0;
        duration_total_r  <= '0;
      end else begin
        status_r          <= 1'b0;
        track_slot_r      <= 3'(slot_r);
        sample_number_r   <= upd.samples;
        sample_offset_r   <= offset;
        run_index_r       <= upd.runs - 32'd1;
        run_count_r       <= upd.run_count;
        run_delta_r       <= upd.run_delta;
        new_run_r         <= !ext_run;
        key_recorded_r    <= key_rec;
        key_entry_count_r <= upd.keys;
        largest_frame_r   <= upd.max_size;
        duration_total_r  <= upd.ticks;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_track_slot      = track_slot_r;
  assign out_sample_number   = sample_number_r;
  assign out_sample_offset   = sample_offset_r;
  assign out_run_index       = run_index_r;
  assign out_run_count       = run_count_r;
  assign out_run_delta       = run_delta_r;
  assign out_new_run         = new_run_r;
  assign out_key_recorded    = key_recorded_r;
  assign out_key_entry_count = key_entry_count_r;
  assign out_largest_frame   = largest_frame_r;
  assign out_duration_total  = duration_total_r;

endmodule
